### sv/lfpe_pkg.sv
// ----------------------------------------------------------------------------
// lfpe_pkg
// Shared types and constants of the LED frame PWM encoder.
// ----------------------------------------------------------------------------
package lfpe_pkg;

    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned LEVEL_W     = 5;
    localparam int unsigned DUTY_W      = 8;
    localparam int unsigned PROD_W      = CHAN_W + LEVEL_W;
    localparam int unsigned BITS_PER_LED = 24;
    localparam int unsigned IDX_W       = 5;

    // full brightness level, and floor(x/20) as (x*3277)>>16, exact for x <= 5100
    localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 5'd20;
    localparam int unsigned        RECIP_W     = 12;
    localparam logic [RECIP_W-1:0] RECIP_20    = 12'd3277;
    localparam int unsigned        RECIP_SHIFT = 16;
    localparam int unsigned        MUL_W       = 24;

    // slot indexes inside one LED
    localparam logic [IDX_W-1:0] LAST_BIT_IDX = 5'd23;
    localparam logic [IDX_W-1:0] GAP_IDX      = 5'd24;

    // register map
    localparam logic [1:0] REG_BRIGHTNESS  = 2'd0;
    localparam logic [1:0] REG_DUTY_ONE    = 2'd1;
    localparam logic [1:0] REG_DUTY_ZERO   = 2'd2;
    localparam logic [1:0] REG_RESET_SLOTS = 2'd3;

    localparam logic [LEVEL_W-1:0] RST_BRIGHTNESS  = 5'd20;
    localparam logic [DUTY_W-1:0]  RST_DUTY_ONE    = 8'd60;
    localparam logic [DUTY_W-1:0]  RST_DUTY_ZERO   = 8'd30;
    localparam logic [7:0]         RST_RESET_SLOTS = 8'd50;

    typedef logic [LEVEL_W-1:0] t_level;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_one;
        logic [DUTY_W-1:0] duty_zero;
        logic [7:0]        reset_slots;
    } t_cfg;

endpackage

### sv/lfpe_if.sv
// ----------------------------------------------------------------------------
// lfpe_if
// Valid/ready channels of the encoder: LED color words in, slot words out.
// ----------------------------------------------------------------------------
interface lfpe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_led;

    modport source (output valid, output red, output green, output blue,
                    output last_led, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_led, output ready);
endinterface

interface lfpe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       gap;
    logic [7:0] gap_length;
    logic       last;

    modport source (output valid, output duty, output gap, output gap_length,
                    output last, input ready);
    modport sink   (input valid, input duty, input gap, input gap_length,
                    input last, output ready);
endinterface

### sv/lfpe_scale_lane.sv
// ----------------------------------------------------------------------------
// lfpe_scale_lane
// One color channel scaled by level/20: multiply, register, reciprocal divide.
// ----------------------------------------------------------------------------
module lfpe_scale_lane (
    input  logic                         i_clk,
    input  logic                         i_en1,
    input  logic                         i_en2,
    input  logic [lfpe_pkg::CHAN_W-1:0]  i_value,
    input  lfpe_pkg::t_level             i_level,
    output logic [lfpe_pkg::CHAN_W-1:0]  o_scaled
);
    import lfpe_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic [MUL_W-1:0]  w_recip;
    logic [CHAN_W-1:0] r_scaled;

    assign n_prod  = PROD_W'(i_value) * PROD_W'(i_level);
    assign w_recip = MUL_W'(r_prod) * MUL_W'(RECIP_20);

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_prod <= n_prod;
        end
        if (i_en2) begin
            r_scaled <= w_recip[RECIP_SHIFT +: CHAN_W];
        end
    end

    assign o_scaled = r_scaled;

endmodule

### sv/lfpe_serializer.sv
// ----------------------------------------------------------------------------
// lfpe_serializer
// Merges the three lane results into one GRB word and shifts it out as slots.
// ----------------------------------------------------------------------------
module lfpe_serializer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_word_valid,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_blue,
    input  logic                  i_is_last,
    input  lfpe_pkg::t_cfg        i_cfg,
    output logic                  o_load,
    lfpe_out_if.source            o_slot
);
    import lfpe_pkg::*;

    logic [BITS_PER_LED-1:0] r_word;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_busy;
    logic                    r_is_last;
    logic                    r_out_valid;
    logic [DUTY_W-1:0]       r_duty;
    logic                    r_gap;
    logic [7:0]              r_gap_length;
    logic                    r_last;

    logic w_adv;
    logic w_final;
    logic w_gap_slot;

    assign w_adv      = r_busy && (!r_out_valid || o_slot.ready);
    assign w_gap_slot = (r_idx == GAP_IDX);
    assign w_final    = r_is_last ? w_gap_slot : (r_idx == LAST_BIT_IDX);
    assign o_load     = i_word_valid && (!r_busy || (w_adv && w_final));

    // slot sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_load) begin
            r_busy    <= 1'b1;
            r_idx     <= '0;
            r_word    <= {i_green, i_red, i_blue};
            r_is_last <= i_is_last;
        end else if (w_adv) begin
            if (w_final) begin
                r_busy <= 1'b0;
            end else begin
                r_idx  <= r_idx + IDX_W'(1);
                r_word <= {r_word[BITS_PER_LED-2:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_slot.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_gap        <= w_gap_slot;
            r_last       <= w_final;
            r_gap_length <= w_gap_slot ? i_cfg.reset_slots : 8'd0;
            if (w_gap_slot) begin
                r_duty <= '0;
            end else begin
                r_duty <= r_word[BITS_PER_LED-1] ? i_cfg.duty_one : i_cfg.duty_zero;
            end
        end
    end

    assign o_slot.valid      = r_out_valid;
    assign o_slot.duty       = r_duty;
    assign o_slot.gap        = r_gap;
    assign o_slot.gap_length = r_gap_length;
    assign o_slot.last       = r_last;

`ifndef SYNTH
    // the gap slot is only reached for the last LED of a frame
    a_gap_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && w_gap_slot |-> r_is_last)
        else $error("gap slot reached for an LED that is not last");

    // a gap word always closes the item and carries zero duty
    a_gap_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_gap |-> r_last && (r_duty == '0))
        else $error("gap word without last or with nonzero duty");

    // a new LED is loaded only when the previous one has no slots left
    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load && r_busy |-> w_adv && w_final)
        else $error("LED word loaded while slots remain");
`endif

endmodule

### sv/led_frame_pwm_encoder.sv
// ----------------------------------------------------------------------------
// led_frame_pwm_encoder
// Turns LED colors into per-bit timer compare words for a one-wire LED strip.
// ----------------------------------------------------------------------------
// Each input word is one LED (red, green, blue, last_led). The three channels
// are scaled by min(brightness,20)/20 in three parallel lanes, then merged
// into a GRB word that is sent as 24 slot words, MSB first: duty_one for a one
// bit, duty_zero for a zero bit. The last LED of a frame adds a 25th word with
// gap=1 and gap_length=reset_slots. The single serializer issues one slot word
// per cycle unless the output stalls on o_slot.ready; the next LED is taken
// while the current one is still shifting out. From input accept, an LED
// passes the first and second lane stages, the serializer load and then the
// output register before its first slot word. Registers sit on an APB-style
// port at byte addresses 0, 4, 8, 12 and should be written only while idle.
// ----------------------------------------------------------------------------
module led_frame_pwm_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // LED color words in, slot words out
    lfpe_in_if.sink     i_pix,
    lfpe_out_if.source  o_slot
);
    import lfpe_pkg::*;

    // configuration registers
    t_level            r_brightness;
    logic [DUTY_W-1:0] r_duty_one;
    logic [DUTY_W-1:0] r_duty_zero;
    logic [7:0]        r_reset_slots;
    logic              w_wr;
    logic [1:0]        w_reg_idx;
    t_cfg              w_cfg;

    // lane pipeline control
    logic   r_s1_valid;
    logic   r_s2_valid;
    logic   r_last1;
    logic   r_last2;
    logic   w_en1;
    logic   w_en2;
    logic   w_load;
    t_level w_level;
    logic [CHAN_W-1:0] w_red_s;
    logic [CHAN_W-1:0] w_green_s;
    logic [CHAN_W-1:0] w_blue_s;

    // register port: always ready, written on the access phase
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness  <= RST_BRIGHTNESS;
            r_duty_one    <= RST_DUTY_ONE;
            r_duty_zero   <= RST_DUTY_ZERO;
            r_reset_slots <= RST_RESET_SLOTS;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_BRIGHTNESS:  r_brightness  <= pwdata[LEVEL_W-1:0];
                REG_DUTY_ONE:    r_duty_one    <= pwdata[DUTY_W-1:0];
                REG_DUTY_ZERO:   r_duty_zero   <= pwdata[DUTY_W-1:0];
                REG_RESET_SLOTS: r_reset_slots <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_BRIGHTNESS:  prdata = 32'(r_brightness);
            REG_DUTY_ONE:    prdata = 32'(r_duty_one);
            REG_DUTY_ZERO:   prdata = 32'(r_duty_zero);
            REG_RESET_SLOTS: prdata = 32'(r_reset_slots);
            default:         prdata = '0;
        endcase
    end

    assign w_cfg.duty_one    = r_duty_one;
    assign w_cfg.duty_zero   = r_duty_zero;
    assign w_cfg.reset_slots = r_reset_slots;

    // anything above full level acts as full level
    assign w_level = (r_brightness > FULL_LEVEL) ? FULL_LEVEL : r_brightness;

    // two-stage lane pipeline; a stage moves when the next one is free or moving
    assign w_en2       = r_s1_valid && (!r_s2_valid || w_load);
    assign i_pix.ready = !r_s1_valid || w_en2;
    assign w_en1       = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_valid <= 1'b1;
            end else if (w_en2) begin
                r_s1_valid <= 1'b0;
            end
            if (w_en2) begin
                r_s2_valid <= 1'b1;
            end else if (w_load) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // last-LED flag follows the lanes
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_last1 <= i_pix.last_led;
        end
        if (w_en2) begin
            r_last2 <= r_last1;
        end
    end

    lfpe_scale_lane u_lane_red (
        .i_clk    (i_clk),
        .i_en1    (w_en1),
        .i_en2    (w_en2),
        .i_value  (i_pix.red),
        .i_level  (w_level),
        .o_scaled (w_red_s)
    );

    lfpe_scale_lane u_lane_green (
        .i_clk    (i_clk),
        .i_en1    (w_en1),
        .i_en2    (w_en2),
        .i_value  (i_pix.green),
        .i_level  (w_level),
        .o_scaled (w_green_s)
    );

    lfpe_scale_lane u_lane_blue (
        .i_clk    (i_clk),
        .i_en1    (w_en1),
        .i_en2    (w_en2),
        .i_value  (i_pix.blue),
        .i_level  (w_level),
        .o_scaled (w_blue_s)
    );

    // merge into GRB order and serialize
    lfpe_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (r_s2_valid),
        .i_green      (w_green_s),
        .i_red        (w_red_s),
        .i_blue       (w_blue_s),
        .i_is_last    (r_last2),
        .i_cfg        (w_cfg),
        .o_load       (w_load),
        .o_slot       (o_slot)
    );

endmodule
